### rtl/core/fdtd_pkg.sv
package fdtd_pkg;

    // grid and number format
    localparam int CELLS     = 1024;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int MATERIALS = 2;
    localparam int MAT_W     = 1;
    localparam int FW        = 32;          // field width, Q16.16
    localparam int FRAC      = 16;          // fraction bits
    localparam int SW        = FW + 2;      // headroom for three-term sums
    localparam int CFG_IDX_W = 3;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic signed [FW-1:0]  t_word;
    typedef logic signed [SW-1:0]  t_wide;
    typedef logic [MAT_W-1:0]      t_mat;
    typedef logic [1:0]            t_cmd;
    typedef logic [1:0]            t_src_kind;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [1:0]            t_cfg_field;

    // commands
    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_STEP = 2'd1;
    localparam t_cmd CMD_READ = 2'd2;

    // source kinds
    localparam t_src_kind SRC_HARD = 2'd1;
    localparam t_src_kind SRC_SOFT = 2'd2;

    // coefficient slot within one material's group of registers
    localparam t_cfg_field CF_SIGMA  = 2'd0;
    localparam t_cfg_field CF_E_COEF = 2'd1;
    localparam t_cfg_field CF_H_COEF = 2'd2;
    localparam t_cfg_field CF_INV_DX = 2'd3;

    typedef struct packed {
        t_word sigma;
        t_word e_coef;
        t_word h_coef;
        t_word inv_dx;
    } t_coef;

    // saturated value with its clip flag
    typedef struct packed {
        logic  sat;
        t_word val;
    } t_clip;

    typedef enum logic [18:0] {
        S_CLEAR  = 19'(1 << 0),
        S_IDLE   = 19'(1 << 1),
        S_RDDATA = 19'(1 << 2),
        S_E_INIT = 19'(1 << 3),
        S_E_LOAD = 19'(1 << 4),
        S_E_MJ   = 19'(1 << 5),
        S_E_MC   = 19'(1 << 6),
        S_E_S    = 19'(1 << 7),
        S_E_MU   = 19'(1 << 8),
        S_E_WR   = 19'(1 << 9),
        S_SRC_RD = 19'(1 << 10),
        S_SRC_WR = 19'(1 << 11),
        S_H_INIT = 19'(1 << 12),
        S_H_LOAD = 19'(1 << 13),
        S_H_D    = 19'(1 << 14),
        S_H_M    = 19'(1 << 15),
        S_H_WR   = 19'(1 << 16),
        S_H_ZERO = 19'(1 << 17),
        S_DONE   = 19'(1 << 18)
    } t_state;

endpackage

### rtl/core/fdtd_ram.sv
module fdtd_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fdtd_qmul.sv
module fdtd_qmul (
    input  logic            i_clk,
    input  fdtd_pkg::t_word i_a,
    input  fdtd_pkg::t_word i_b,
    output fdtd_pkg::t_clip o_q
);
    import fdtd_pkg::*;

    logic signed [2*FW-1:0] r_prod;
    logic                   hi_same;

    // full product registered, result in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // drop fraction bits (floor), then clip to the field range
    assign hi_same = (&r_prod[2*FW-1:FW-1+FRAC]) | ~(|r_prod[2*FW-1:FW-1+FRAC]);

    always_comb begin
        o_q.sat = ~hi_same;
        if (hi_same) begin
            o_q.val = r_prod[FW-1+FRAC:FRAC];
        end else if (r_prod[2*FW-1]) begin
            o_q.val = {1'b1, {(FW-1){1'b0}}};
        end else begin
            o_q.val = {1'b0, {(FW-1){1'b1}}};
        end
    end

endmodule

### rtl/core/fdtd_1d_field_update_core.sv
// 1-D Yee-grid field engine. The grid of CELLS cells (E, H, P, material) lives in four
// block memories. Commands: load a cell, read a cell back, or run one time step (E pass,
// source, H pass, H[0] forced to zero); every command returns exactly one result. All
// arithmetic is Q16.16 with floor-rounded products and saturation; the saturated flag of
// a step result reports any clipping inside that step. After reset the block zeroes
// the memories before it accepts anything (configuration writes are taken at any
// time). A time step works through the cells one at a time, E pass then H pass, on the
// single shared 32x32 multiplier, which the E update needs three times and the H
// update once. A finished result sits in the output register, and the next command
// is accepted while it waits; a command only stalls at its end if the previous
// result has still not been taken.
module fdtd_1d_field_update_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  fdtd_pkg::t_cfg_idx    i_cfg_index,
    input  fdtd_pkg::t_word       i_cfg_data,
    // command channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fdtd_pkg::t_cmd        i_cmd,
    input  fdtd_pkg::t_addr       i_cell_index,
    input  fdtd_pkg::t_word       i_load_e,
    input  fdtd_pkg::t_word       i_load_h,
    input  fdtd_pkg::t_word       i_load_p,
    input  fdtd_pkg::t_mat        i_load_material,
    input  fdtd_pkg::t_word       i_source_value,
    input  fdtd_pkg::t_addr       i_source_position,
    input  fdtd_pkg::t_src_kind   i_source_kind,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output fdtd_pkg::t_word       o_e_out,
    output fdtd_pkg::t_word       o_h_out,
    output fdtd_pkg::t_word       o_p_out,
    output fdtd_pkg::t_mat        o_material_out,
    output logic                  o_saturated
);
    import fdtd_pkg::*;

    function automatic t_wide f_wide(input t_word w);
        return SW'(w);
    endfunction

    // clip a wide sum to the field range
    function automatic t_clip f_clip(input t_wide v);
        t_clip c;
        logic  hi_same;
        hi_same = (&v[SW-1:FW-1]) | ~(|v[SW-1:FW-1]);
        c.sat = ~hi_same;
        if (hi_same) begin
            c.val = v[FW-1:0];
        end else if (v[SW-1]) begin
            c.val = {1'b1, {(FW-1){1'b0}}};
        end else begin
            c.val = {1'b0, {(FW-1){1'b1}}};
        end
        return c;
    endfunction

    // sequencer and control
    t_state    r_state, n_state;
    t_addr     r_idx, n_idx;          // cell counter, also the clear sweep address
    logic      r_out_valid, n_out_valid;
    logic      r_sat, n_sat;          // sticky clip flag of the running step
    t_coef     r_coef [MATERIALS];

    // command fields held for the whole command
    t_addr     r_cell;
    t_addr     r_src_pos;
    t_word     r_src_val;
    t_src_kind r_src_kind;

    // datapath registers
    t_word     r_prev;                // H[i] in the E pass, E[i-1] in the H pass
    t_word     r_base;                // field being updated: E[i] or H[i]
    t_word     r_p;
    t_word     r_diff;
    t_word     r_s;
    t_wide     r_jp;                  // -j - P, exact
    t_mat      r_mat;

    // pending result and output register
    t_word     r_res_e, r_res_h, r_res_p;
    t_mat      r_res_m;
    t_word     r_out_e, r_out_h, r_out_p;
    t_mat      r_out_m;
    logic      r_out_sat;

    // memory ports
    logic      e_we, h_we, pm_we;
    t_addr     e_waddr, h_waddr, pm_waddr;
    t_word     e_wdata, h_wdata, p_wdata;
    t_mat      m_wdata;
    t_addr     rd_addr, h_rd_addr;
    t_word     e_rd, h_rd, p_rd;
    t_mat      m_rd;

    // shared multiplier
    t_word     mul_a, mul_b;
    t_clip     mq;
    t_mat      coef_mat;
    t_coef     coef;

    t_clip     d_clip, s_clip, u_clip, src_clip;
    t_word     diff_src;
    logic      sat_hit;
    logic      accept, out_free, cell_ok, rd_cell_ok, src_ok, load_ok;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid & o_ready;
    assign out_free    = ~r_out_valid | i_ready;

    assign cell_ok    = (32'(i_cell_index) < CELLS);
    assign rd_cell_ok = (32'(r_cell) < CELLS);
    assign src_ok     = (32'(r_src_pos) < CELLS) &&
                        ((r_src_kind == SRC_HARD) || (r_src_kind == SRC_SOFT));
    assign load_ok    = accept && (i_cmd == CMD_LOAD) && cell_ok;

    //------------------------------------------------------------------
    // grid memories
    //------------------------------------------------------------------
    fdtd_ram #(.W(FW), .DEPTH(CELLS)) u_e_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (rd_addr),
        .o_rdata (e_rd)
    );

    fdtd_ram #(.W(FW), .DEPTH(CELLS)) u_h_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_rd_addr),
        .o_rdata (h_rd)
    );

    fdtd_ram #(.W(FW), .DEPTH(CELLS)) u_p_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (p_wdata),
        .i_raddr (rd_addr),
        .o_rdata (p_rd)
    );

    fdtd_ram #(.W(MAT_W), .DEPTH(CELLS)) u_m_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (m_wdata),
        .i_raddr (rd_addr),
        .o_rdata (m_rd)
    );

    //------------------------------------------------------------------
    // read addresses: one shared address, H runs one cell ahead in the E pass
    //------------------------------------------------------------------
    always_comb begin
        case (r_state)
            S_IDLE:             rd_addr = i_cell_index;
            S_E_WR, S_H_WR:     rd_addr = r_idx + ADDR_W'(1);    // prefetch next cell
            S_SRC_RD:           rd_addr = r_src_pos;
            S_E_INIT, S_H_INIT: rd_addr = '0;
            default:            rd_addr = r_idx;
        endcase
        if ((r_state == S_E_LOAD) || (r_state == S_E_WR)) begin
            h_rd_addr = rd_addr + ADDR_W'(1);
        end else begin
            h_rd_addr = rd_addr;
        end
    end

    //------------------------------------------------------------------
    // write ports
    //------------------------------------------------------------------
    always_comb begin
        e_we     = 1'b0;
        h_we     = 1'b0;
        pm_we    = 1'b0;
        e_waddr  = r_idx;
        h_waddr  = r_idx;
        pm_waddr = r_idx;
        e_wdata  = '0;
        h_wdata  = '0;
        p_wdata  = '0;
        m_wdata  = '0;
        case (r_state)
            S_CLEAR: begin
                // zero sweep after reset
                e_we  = 1'b1;
                h_we  = 1'b1;
                pm_we = 1'b1;
            end
            S_IDLE: begin
                // cell load is written in the transfer cycle
                e_we     = load_ok;
                h_we     = load_ok;
                pm_we    = load_ok;
                e_waddr  = i_cell_index;
                h_waddr  = i_cell_index;
                pm_waddr = i_cell_index;
                e_wdata  = i_load_e;
                h_wdata  = i_load_h;
                p_wdata  = i_load_p;
                m_wdata  = i_load_material;
            end
            S_E_WR: begin
                e_we    = 1'b1;
                e_wdata = u_clip.val;
            end
            S_SRC_WR: begin
                e_we    = src_ok;
                e_waddr = r_src_pos;
                e_wdata = src_clip.val;
            end
            S_H_WR: begin
                h_we    = 1'b1;
                h_wdata = u_clip.val;
            end
            S_H_ZERO: begin
                // H at the left boundary is held at zero
                h_we    = 1'b1;
                h_waddr = '0;
            end
            default: begin
            end
        endcase
    end

    //------------------------------------------------------------------
    // shared multiplier operand select
    //------------------------------------------------------------------
    // material comes straight from memory in the first E step, latched after that
    assign coef_mat = (r_state == S_E_MJ) ? m_rd : r_mat;
    assign coef     = r_coef[coef_mat];

    always_comb begin
        case (r_state)
            S_E_MJ: begin
                mul_a = coef.sigma;          // j = sigma * E
                mul_b = e_rd;
            end
            S_E_MC: begin
                mul_a = coef.inv_dx;         // c = dH * dxinv
                mul_b = r_diff;
            end
            S_E_MU: begin
                mul_a = coef.e_coef;         // u = ce * s
                mul_b = r_s;
            end
            S_H_M: begin
                mul_a = coef.h_coef;         // ch * dE
                mul_b = r_diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fdtd_qmul u_qmul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_q   (mq)
    );

    //------------------------------------------------------------------
    // adders with saturation
    //------------------------------------------------------------------
    assign diff_src = (r_state == S_E_MJ) ? h_rd : e_rd;
    assign d_clip   = f_clip(f_wide(diff_src) - f_wide(r_prev));
    assign s_clip   = f_clip(r_jp + f_wide(mq.val));
    assign u_clip   = f_clip(f_wide(r_base) + f_wide(mq.val));
    assign src_clip = f_clip(((r_src_kind == SRC_SOFT) ? f_wide(e_rd) : t_wide'(0)) +
                             f_wide(r_src_val));

    // clip events, counted only in the cycle that consumes the value
    always_comb begin
        case (r_state)
            S_E_MJ, S_H_D:  sat_hit = d_clip.sat;
            S_E_MC:         sat_hit = mq.sat;
            S_E_S:          sat_hit = mq.sat | s_clip.sat;
            S_E_WR, S_H_WR: sat_hit = mq.sat | u_clip.sat;
            S_SRC_WR:       sat_hit = src_ok & src_clip.sat;
            default:        sat_hit = 1'b0;
        endcase
    end

    //------------------------------------------------------------------
    // sequencer
    //------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_idx = r_idx + ADDR_W'(1);
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_sat = 1'b0;
                    case (i_cmd)
                        CMD_STEP: n_state = S_E_INIT;
                        CMD_READ: n_state = S_RDDATA;
                        default:  n_state = S_DONE;    // load, unused code
                    endcase
                end
            end
            S_RDDATA: n_state = S_DONE;
            S_E_INIT: begin
                n_idx   = '0;
                n_state = S_E_LOAD;
            end
            S_E_LOAD: n_state = S_E_MJ;
            S_E_MJ:   n_state = S_E_MC;
            S_E_MC:   n_state = S_E_S;
            S_E_S:    n_state = S_E_MU;
            S_E_MU:   n_state = S_E_WR;
            S_E_WR: begin
                // last cell keeps its E, the pass stops one short
                if (r_idx == ADDR_W'(CELLS - 2)) begin
                    n_state = S_SRC_RD;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_E_MJ;
                end
            end
            S_SRC_RD: n_state = S_SRC_WR;
            S_SRC_WR: n_state = S_H_INIT;
            S_H_INIT: begin
                n_idx   = ADDR_W'(1);
                n_state = S_H_LOAD;
            end
            S_H_LOAD: n_state = S_H_D;
            S_H_D:    n_state = S_H_M;
            S_H_M:    n_state = S_H_WR;
            S_H_WR: begin
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_H_ZERO;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_H_D;
                end
            end
            S_H_ZERO: n_state = S_DONE;
            S_DONE: begin
                // wait for the output register to free up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_sat = n_sat | sat_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int m = 0; m < MATERIALS; m++) begin
                r_coef[m] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            // register i: material i/4, slot i%4
            if (i_cfg_valid) begin
                case (t_cfg_field'(i_cfg_index[1:0]))
                    CF_SIGMA:  r_coef[i_cfg_index[CFG_IDX_W-1 -: MAT_W]].sigma  <= i_cfg_data;
                    CF_E_COEF: r_coef[i_cfg_index[CFG_IDX_W-1 -: MAT_W]].e_coef <= i_cfg_data;
                    CF_H_COEF: r_coef[i_cfg_index[CFG_IDX_W-1 -: MAT_W]].h_coef <= i_cfg_data;
                    CF_INV_DX: r_coef[i_cfg_index[CFG_IDX_W-1 -: MAT_W]].inv_dx <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    //------------------------------------------------------------------
    // datapath registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cell     <= i_cell_index;
                    r_src_pos  <= i_source_position;
                    r_src_val  <= i_source_value;
                    r_src_kind <= i_source_kind;
                    r_res_e    <= '0;
                    r_res_h    <= '0;
                    r_res_p    <= '0;
                    r_res_m    <= '0;
                end
            end
            S_RDDATA: begin
                if (rd_cell_ok) begin
                    r_res_e <= e_rd;
                    r_res_h <= h_rd;
                    r_res_p <= p_rd;
                    r_res_m <= m_rd;
                end
            end
            S_E_LOAD: r_prev <= h_rd;                // H[0]
            S_E_MJ: begin
                r_base <= e_rd;
                r_p    <= p_rd;
                r_mat  <= m_rd;
                r_diff <= d_clip.val;                // H[i+1] - H[i]
                r_prev <= h_rd;                      // becomes H[i] of the next cell
            end
            S_E_MC:   r_jp <= -f_wide(mq.val) - f_wide(r_p);
            S_E_S:    r_s  <= s_clip.val;
            S_H_LOAD: r_prev <= e_rd;                // E[0]
            S_H_D: begin
                r_diff <= d_clip.val;                // E[i] - E[i-1]
                r_prev <= e_rd;
                r_base <= h_rd;
                r_mat  <= m_rd;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_e   <= r_res_e;
                    r_out_h   <= r_res_h;
                    r_out_p   <= r_res_p;
                    r_out_m   <= r_res_m;
                    r_out_sat <= r_sat;              // cleared at transfer, set by steps only
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_e_out        = r_out_e;
    assign o_h_out        = r_out_h;
    assign o_p_out        = r_out_p;
    assign o_material_out = r_out_m;
    assign o_saturated    = r_out_sat;

endmodule

### sim/fdtd_grid_checker.sv
module fdtd_grid_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  fdtd_pkg::t_cfg_idx   i_cfg_index,
    input  fdtd_pkg::t_word      i_cfg_data,
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_ready,
    input  fdtd_pkg::t_cmd       i_cmd,
    input  fdtd_pkg::t_addr      i_cell_index,
    input  fdtd_pkg::t_word      i_load_e,
    input  fdtd_pkg::t_word      i_load_h,
    input  fdtd_pkg::t_word      i_load_p,
    input  fdtd_pkg::t_mat       i_load_material,
    input  fdtd_pkg::t_word      i_source_value,
    input  fdtd_pkg::t_addr      i_source_position,
    input  fdtd_pkg::t_src_kind  i_source_kind,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  fdtd_pkg::t_word      i_e_out,
    input  fdtd_pkg::t_word      i_h_out,
    input  fdtd_pkg::t_word      i_p_out,
    input  fdtd_pkg::t_mat       i_material_out,
    input  logic                 i_saturated,
    output int                   o_mismatches,
    output int                   o_outstanding
);
    import fdtd_pkg::*;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct packed {
        t_word e;
        t_word h;
        t_word p;
        t_mat  mat;
        logic  sat;
    } t_cell_readout;

    t_word         grid_e [CELLS];
    t_word         grid_h [CELLS];
    t_word         grid_p [CELLS];
    t_mat          grid_mat [CELLS];
    t_coef         coef_by_mat [MATERIALS];
    bit            step_clipped;
    t_cell_readout pending_readouts [$];
    int            fail_count;
    int            shown;

    // clip to the field range, remembering that it happened
    function automatic longint saturate(input longint v);
        if (v > WORD_MAX) begin
            step_clipped = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            step_clipped = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // q16.16 product, floor rounding
    function automatic longint q_mul(input longint a, input longint b);
        longint prod;
        prod = a * b;
        return saturate(prod >>> FRAC);
    endfunction

    task automatic advance_grid(input t_word src, input t_addr pos, input t_src_kind kind);
        t_coef  k;
        longint j;
        longint dh;
        longint c;
        longint s;
        longint u;
        longint de;
        step_clipped = 1'b0;
        // e pass, last cell left alone
        for (int i = 0; i < CELLS - 1; i++) begin
            k = coef_by_mat[grid_mat[i]];
            j = q_mul(k.sigma, grid_e[i]);
            dh = saturate(longint'(grid_h[i + 1]) - longint'(grid_h[i]));
            c = q_mul(dh, k.inv_dx);
            s = saturate(-j - longint'(grid_p[i]) + c);
            u = q_mul(k.e_coef, s);
            grid_e[i] = t_word'(saturate(longint'(grid_e[i]) + u));
        end
        case (kind)
            SRC_HARD: grid_e[pos] = src;
            SRC_SOFT: grid_e[pos] = t_word'(saturate(longint'(grid_e[pos]) + longint'(src)));
            default: ;
        endcase
        // h pass on the new e
        for (int i = 1; i < CELLS; i++) begin
            k = coef_by_mat[grid_mat[i]];
            de = saturate(longint'(grid_e[i]) - longint'(grid_e[i - 1]));
            grid_h[i] = t_word'(saturate(longint'(grid_h[i]) + q_mul(k.h_coef, de)));
        end
        grid_h[0] = '0;
    endtask

    always @(posedge i_clk) begin : watch
        t_cell_readout want;
        t_cell_readout got;
        t_cfg_field    fld;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                grid_e[i] = '0;
                grid_h[i] = '0;
                grid_p[i] = '0;
                grid_mat[i] = '0;
            end
            for (int m = 0; m < MATERIALS; m++) coef_by_mat[m] = '0;
            pending_readouts.delete();
            fail_count = 0;
            shown = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                fld = t_cfg_field'(i_cfg_index[1:0]);
                case (fld)
                    CF_SIGMA:  coef_by_mat[i_cfg_index[2]].sigma = i_cfg_data;
                    CF_E_COEF: coef_by_mat[i_cfg_index[2]].e_coef = i_cfg_data;
                    CF_H_COEF: coef_by_mat[i_cfg_index[2]].h_coef = i_cfg_data;
                    CF_INV_DX: coef_by_mat[i_cfg_index[2]].inv_dx = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got.e = i_e_out;
                got.h = i_h_out;
                got.p = i_p_out;
                got.mat = i_material_out;
                got.sat = i_saturated;
                if (pending_readouts.size() == 0) begin
                    fail_count++;
                    if (shown < 10)
                        $display("unexpected result: e=%h h=%h p=%h mat=%0d sat=%0d",
                                 got.e, got.h, got.p, got.mat, got.sat);
                    shown++;
                end else begin
                    want = pending_readouts.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (shown < 10)
                            $display("result mismatch: expected e=%h h=%h p=%h mat=%0d sat=%0d,",
                                     want.e, want.h, want.p, want.mat, want.sat,
                                     " got e=%h h=%h p=%h mat=%0d sat=%0d",
                                     got.e, got.h, got.p, got.mat, got.sat);
                        shown++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                want = '0;
                case (i_cmd)
                    CMD_LOAD: begin
                        grid_e[i_cell_index] = i_load_e;
                        grid_h[i_cell_index] = i_load_h;
                        grid_p[i_cell_index] = i_load_p;
                        grid_mat[i_cell_index] = i_load_material;
                    end
                    CMD_STEP: begin
                        advance_grid(i_source_value, i_source_position, i_source_kind);
                        want.sat = step_clipped;
                    end
                    CMD_READ: begin
                        want.e = grid_e[i_cell_index];
                        want.h = grid_h[i_cell_index];
                        want.p = grid_p[i_cell_index];
                        want.mat = grid_mat[i_cell_index];
                    end
                    default: ;
                endcase
                pending_readouts = {pending_readouts, want};
            end
        end
        o_mismatches <= fail_count;
        o_outstanding <= pending_readouts.size();
    end

endmodule

### sim/tb_fdtd_1d_field_update_core.sv
module tb_fdtd_1d_field_update_core;
    import fdtd_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    // a time step alone sweeps the whole grid with no transfer at all
    localparam int STALL_LIMIT     = 50000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 45;
    localparam int TAIL_CYCLES     = 50;
    localparam int FRAC_ONE        = 1 << FRAC;

    // codes the package leaves unnamed
    localparam t_cmd      CMD_NOP    = 2'd3;
    localparam t_src_kind SRC_NONE   = 2'd0;
    localparam t_src_kind SRC_UNUSED = 2'd3;

    localparam t_word Q_MAX = 32'sh7FFF_FFFF;
    localparam t_word Q_MIN = 32'sh8000_0000;
    localparam t_word Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        t_cmd      cmd;
        t_addr     cell_idx;
        t_word     e;
        t_word     h;
        t_word     p;
        t_mat      mat;
        t_word     src_val;
        t_addr     src_pos;
        t_src_kind src_kind;
    } t_grid_cmd;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index;
    t_word     i_cfg_data;
    logic      i_valid;
    logic      o_ready;
    t_cmd      i_cmd;
    t_addr     i_cell_index;
    t_word     i_load_e;
    t_word     i_load_h;
    t_word     i_load_p;
    t_mat      i_load_material;
    t_word     i_source_value;
    t_addr     i_source_position;
    t_src_kind i_source_kind;
    logic      o_valid;
    logic      i_ready;
    t_word     o_e_out;
    t_word     o_h_out;
    t_word     o_p_out;
    t_mat      o_material_out;
    logic      o_saturated;

    int mismatches;
    int outstanding;
    int commands_sent;
    int burst_left;
    // raised by the stimulus while it floods the command channel
    logic flood_req;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    fdtd_1d_field_update_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_cell_index      (i_cell_index),
        .i_load_e          (i_load_e),
        .i_load_h          (i_load_h),
        .i_load_p          (i_load_p),
        .i_load_material   (i_load_material),
        .i_source_value    (i_source_value),
        .i_source_position (i_source_position),
        .i_source_kind     (i_source_kind),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_e_out           (o_e_out),
        .o_h_out           (o_h_out),
        .o_p_out           (o_p_out),
        .o_material_out    (o_material_out),
        .o_saturated       (o_saturated)
    );

    fdtd_grid_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd_valid       (i_valid),
        .i_cmd_ready       (o_ready),
        .i_cmd             (i_cmd),
        .i_cell_index      (i_cell_index),
        .i_load_e          (i_load_e),
        .i_load_h          (i_load_h),
        .i_load_p          (i_load_p),
        .i_load_material   (i_load_material),
        .i_source_value    (i_source_value),
        .i_source_position (i_source_position),
        .i_source_kind     (i_source_kind),
        .i_res_valid       (o_valid),
        .i_res_ready       (i_ready),
        .i_e_out           (o_e_out),
        .i_h_out           (o_h_out),
        .i_p_out           (o_p_out),
        .i_material_out    (o_material_out),
        .i_saturated       (o_saturated),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    // uniform value in [-limit, limit]
    function automatic t_word small_q(input int limit);
        return t_word'(int'($urandom_range(0, 2 * limit)) - limit);
    endfunction

    // field values: extremes, values near the origin, anything at all
    function automatic t_word pick_value();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return t_word'($urandom_range(0, 2)) - t_word'(1);
            3, 4, 5: return small_q(4 * FRAC_ONE);
            default: return t_word'($urandom());
        endcase
    endfunction

    // every field random, so the unused ones toggle too
    function automatic t_grid_cmd random_payload();
        t_grid_cmd c;
        c.cmd = t_cmd'($urandom_range(0, 3));
        c.cell_idx = t_addr'($urandom());
        c.e = t_word'($urandom());
        c.h = t_word'($urandom());
        c.p = t_word'($urandom());
        c.mat = t_mat'($urandom_range(0, 1));
        c.src_val = t_word'($urandom());
        c.src_pos = t_addr'($urandom());
        c.src_kind = t_src_kind'($urandom_range(0, 3));
        return c;
    endfunction

    function automatic t_grid_cmd load_cmd(input t_addr cell_idx, input t_word e,
                                           input t_word h, input t_word p, input t_mat mat);
        t_grid_cmd c;
        c = random_payload();
        c.cmd = CMD_LOAD;
        c.cell_idx = cell_idx;
        c.e = e;
        c.h = h;
        c.p = p;
        c.mat = mat;
        return c;
    endfunction

    function automatic t_grid_cmd read_cmd(input t_addr cell_idx);
        t_grid_cmd c;
        c = random_payload();
        c.cmd = CMD_READ;
        c.cell_idx = cell_idx;
        return c;
    endfunction

    function automatic t_grid_cmd step_cmd(input t_word v, input t_addr pos,
                                           input t_src_kind kind);
        t_grid_cmd c;
        c = random_payload();
        c.cmd = CMD_STEP;
        c.src_val = v;
        c.src_pos = pos;
        c.src_kind = kind;
        return c;
    endfunction

    // a cell within spread of center, clamped to the grid
    function automatic t_addr near_cell(input t_addr center, input int spread);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > CELLS - 1) v = CELLS - 1;
        return t_addr'(v);
    endfunction

    // coefficient sets, one per random phase; extremes and physical ones among them
    function automatic t_coef material_setting(input int phase, input int m);
        t_coef k;
        case (phase)
            0: begin
                k.sigma = m ? 32'sh0000_2000 : 32'sh0000_0800;
                k.e_coef = m ? 32'sh0000_4000 : 32'sh0000_8000;
                k.h_coef = m ? 32'sh0000_6000 : 32'sh0000_8000;
                k.inv_dx = m ? 32'sh0002_0000 : Q_ONE;
            end
            1: k = t_coef'({$urandom(), $urandom(), $urandom(), $urandom()});
            2: begin
                k.sigma = small_q(2 * FRAC_ONE);
                k.e_coef = small_q(2 * FRAC_ONE);
                k.h_coef = small_q(2 * FRAC_ONE);
                k.inv_dx = small_q(2 * FRAC_ONE);
            end
            3: k = m ? t_coef'({4{Q_MIN}}) : t_coef'({4{Q_MAX}});
            4: k = m ? t_coef'({$urandom(), $urandom(), $urandom(), $urandom()}) : '0;
            default: begin
                k.sigma = t_word'($urandom_range(0, FRAC_ONE / 16));
                k.e_coef = t_word'($urandom_range(0, FRAC_ONE));
                k.h_coef = t_word'($urandom_range(0, FRAC_ONE));
                k.inv_dx = t_word'($urandom_range(FRAC_ONE, 2 * FRAC_ONE));
            end
        endcase
        return k;
    endfunction

    // one command transfer, then either stay in the burst or open a gap
    task automatic issue_command(input t_grid_cmd c);
        i_cmd <= c.cmd;
        i_cell_index <= c.cell_idx;
        i_load_e <= c.e;
        i_load_h <= c.h;
        i_load_p <= c.p;
        i_load_material <= c.mat;
        i_source_value <= c.src_val;
        i_source_position <= c.src_pos;
        i_source_kind <= c.src_kind;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        commands_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // all eight registers, only with the block idle
    task automatic program_materials(input t_coef m0, input t_coef m1);
        t_coef      pick;
        t_cfg_field fld;
        drain();
        i_cfg_valid <= 1'b1;
        for (int m = 0; m < MATERIALS; m++) begin
            pick = m ? m1 : m0;
            for (int f = 0; f < 4; f++) begin
                fld = t_cfg_field'(f);
                i_cfg_index <= t_cfg_idx'({1'(m), fld});
                case (fld)
                    CF_SIGMA:  i_cfg_data <= pick.sigma;
                    CF_E_COEF: i_cfg_data <= pick.e_coef;
                    CF_H_COEF: i_cfg_data <= pick.h_coef;
                    default:   i_cfg_data <= pick.inv_dx;
                endcase
                @(posedge i_clk);
                while (!o_cfg_ready) @(posedge i_clk);
            end
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: stall patterns that change every so often, plus one long hold-off
    initial begin
        int hold_left;
        bit hold_used;
        int mode;
        int mode_left;
        int stall_tick;
        hold_left = 0;
        hold_used = 1'b0;
        mode = 0;
        mode_left = 0;
        stall_tick = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            stall_tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (flood_req && !hold_used) begin
                // let the block fill up while commands keep coming
                hold_used = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (stall_tick % 5) < 3;
                endcase
            end
        end
    end

    // watchdog: too long without any transfer on any channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL fdtd_1d_field_update_core");
        $finish;
    end

    // stimulus
    initial begin
        t_addr     center;
        t_grid_cmd noise;
        t_src_kind kind;
        int        phase_end;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_cmd = CMD_LOAD;
        i_cell_index = '0;
        i_load_e = '0;
        i_load_h = '0;
        i_load_p = '0;
        i_load_material = '0;
        i_source_value = '0;
        i_source_position = '0;
        i_source_kind = SRC_NONE;
        flood_req = 1'b0;
        commands_sent = 0;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset coefficients: grid ends, extreme values, all command codes
        issue_command(load_cmd(t_addr'(0), Q_MAX, Q_MAX, Q_MIN, t_mat'(1)));
        issue_command(load_cmd(t_addr'(CELLS - 1), Q_MIN, Q_MIN, Q_MAX, t_mat'(0)));
        issue_command(load_cmd(t_addr'(1), -t_word'(1), t_word'(1), '0, t_mat'(1)));
        issue_command(read_cmd(t_addr'(0)));
        issue_command(read_cmd(t_addr'(CELLS - 1)));
        noise = random_payload();
        noise.cmd = CMD_NOP;
        issue_command(noise);
        // hard source on the last cell, which the e pass never touches
        issue_command(step_cmd(Q_MAX, t_addr'(CELLS - 1), SRC_HARD));
        issue_command(read_cmd(t_addr'(CELLS - 1)));
        // h of cell 0 is forced to zero by the step
        issue_command(read_cmd(t_addr'(0)));
        issue_command(read_cmd(t_addr'(1)));
        issue_command(step_cmd(Q_MAX, t_addr'(0), SRC_UNUSED));
        issue_command(step_cmd(Q_MIN, t_addr'(5), SRC_NONE));

        // largest coefficients everywhere, soft source pushing the low end
        program_materials(t_coef'({4{Q_MAX}}), t_coef'({4{Q_MAX}}));
        issue_command(step_cmd(Q_MIN, t_addr'(0), SRC_SOFT));
        issue_command(read_cmd(t_addr'(0)));
        issue_command(read_cmd(t_addr'(1)));
        issue_command(read_cmd(t_addr'(CELLS - 2)));
        issue_command(read_cmd(t_addr'(CELLS - 1)));

        // most negative coefficients, a small disturbance mid-grid
        program_materials(t_coef'({4{Q_MIN}}), t_coef'({4{Q_MIN}}));
        issue_command(load_cmd(t_addr'(512), t_word'(1), -t_word'(1), '0, t_mat'(1)));
        issue_command(step_cmd(32'sh0001_8000, t_addr'(512), SRC_SOFT));
        issue_command(read_cmd(t_addr'(511)));
        issue_command(read_cmd(t_addr'(512)));
        issue_command(read_cmd(t_addr'(513)));

        // random phases, each under its own coefficient set
        for (int phase = 0; phase < PHASES; phase++) begin
            program_materials(material_setting(phase, 0), material_setting(phase, 1));
            phase_end = commands_sent + PHASE_ITEMS;
            if (phase == 2) begin
                // back-to-back loads and reads against a held-off result side
                center = t_addr'($urandom());
                flood_req <= 1'b1;
                burst_left = 1000;
                for (int k = 0; k < 16; k++) begin
                    if (k % 2)
                        issue_command(read_cmd(near_cell(center, 2)));
                    else
                        issue_command(load_cmd(near_cell(center, 2), pick_value(), pick_value(),
                                               pick_value(), t_mat'($urandom_range(0, 1))));
                end
                burst_left = 0;
                flood_req <= 1'b0;
            end
            while (commands_sent < phase_end) begin
                if ($urandom_range(0, 3) != 0) begin
                    // load a neighborhood, step with a source there, read it back
                    case ($urandom_range(0, 7))
                        0: center = t_addr'(0);
                        1: center = t_addr'(CELLS - 1);
                        2: center = t_addr'($urandom_range(0, 1) ? 1 : CELLS - 2);
                        default: center = t_addr'($urandom());
                    endcase
                    repeat ($urandom_range(1, 3))
                        issue_command(load_cmd(near_cell(center, 2), pick_value(), pick_value(),
                                               pick_value(), t_mat'($urandom_range(0, 1))));
                    case ($urandom_range(0, 9))
                        0: kind = SRC_NONE;
                        1: kind = SRC_UNUSED;
                        2, 3, 4, 5: kind = SRC_SOFT;
                        default: kind = SRC_HARD;
                    endcase
                    issue_command(step_cmd(pick_value(),
                                           ($urandom_range(0, 4) != 0) ? center
                                                                      : t_addr'($urandom()),
                                           kind));
                    repeat ($urandom_range(1, 3))
                        issue_command(read_cmd(near_cell(center, 3)));
                end else begin
                    // stray command, steps kept rare since each one sweeps the grid
                    noise = random_payload();
                    if (noise.cmd == CMD_STEP && $urandom_range(0, 3) != 0)
                        noise.cmd = CMD_READ;
                    issue_command(noise);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS fdtd_1d_field_update_core");
        else
            $display("FAIL fdtd_1d_field_update_core");
        $finish;
    end

endmodule
